// ===== design/cpg_pkg.sv =====
// Shared constants for the circle point generator.
// Coordinate width default and the reflection codes; no dependencies.
`default_nettype none

package cpg_pkg;

	localparam int COORD_BITS_DEF = 10;

	// reflection codes, in emission order
	localparam logic [2:0] OCT_XY   = 3'd0;
	localparam logic [2:0] OCT_YX   = 3'd1;
	localparam logic [2:0] OCT_NYX  = 3'd2;
	localparam logic [2:0] OCT_NXY  = 3'd3;
	localparam logic [2:0] OCT_NXNY = 3'd4;
	localparam logic [2:0] OCT_NYNX = 3'd5;
	localparam logic [2:0] OCT_YNX  = 3'd6;
	localparam logic [2:0] OCT_XNY  = 3'd7;

endpackage

`default_nettype wire

// ===== design/cpg_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Uses cpg_pkg for the default width.
`default_nettype none

module cpg_sqrt #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [2*COORD_BITS-1:0]   n,
	output logic                           done,
	output logic [COORD_BITS-1:0]          root,
	output logic [COORD_BITS+1:0]          rem
);
	import cpg_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int CNTW = $clog2(C + 1);

	logic [2*C-1:0]  n_q;
	logic [C+1:0]    rem_q;
	logic [C-1:0]    root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [C+3:0] rem_sh;
	logic [C+3:0] trial;
	logic         take;

	always_comb begin
		rem_sh = {rem_q, n_q[2*C-1:2*C-2]};
		trial  = {2'b00, root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(C);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[2*C-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sh[C+1:0] - trial[C+1:0];
				root_q <= {root_q[C-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[C+1:0];
				root_q <= {root_q[C-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== design/circle_polynomial_point_generator_core.sv =====
// Circle point generator: each input item advances (or restarts) one column x of the first
// octant; a drawn column yields the eight reflections of (x, round(sqrt(r*r - x*x))). An
// advance while no circle is active gives nothing; a column past the arc end gives nothing
// after two squarings on the shared multiplier and a compare. A drawn column goes through
// those steps, a squaring of x + 1, the square-root unit (one root bit per cycle) and a
// rounding step to the first point, and then gives its points at one point per cycle while
// out_ready is high. Only one item is in work at a time.
// Depends on cpg_pkg and cpg_sqrt.
`default_nettype none

module circle_polynomial_point_generator_core #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         radius_we,
	input  wire logic [COORD_BITS-1:0]        radius_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         restart,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS:0]        point_x,
	output logic signed [COORD_BITS:0]        point_y,
	output logic [2:0]                        octant,
	output logic                              last_of_run,
	output logic                              arc_done
);
	import cpg_pkg::*;

	localparam int C = COORD_BITS;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RR    = 8'b0000_0010,
		S_XX    = 8'b0000_0100,
		S_CHK   = 8'b0000_1000,
		S_NX    = 8'b0001_0000,
		S_SQRT  = 8'b0010_0000,
		S_ROUND = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [C-1:0]    radius_q;
	logic [C-1:0]    column_q;
	logic            finished_q;
	logic [2*C-1:0]  rr_q;
	logic [2*C-1:0]  xx_q;
	logic            done_q;
	logic [C-1:0]    y_q;
	logic [2:0]      oct_q;

	// shared squaring unit
	logic [C:0]      mul_a;
	logic [2*C+1:0]  prod;
	logic            past_end;
	logic            sqrt_start;
	logic            sqrt_done;
	logic [C-1:0]    sqrt_root;
	logic [C+1:0]    sqrt_rem;
	logic [C:0]      y_up;

	always_comb begin
		unique case (state_q)
			S_RR:    mul_a = {1'b0, radius_q};
			S_NX:    mul_a = {1'b0, column_q} + (C+1)'(1);
			default: mul_a = {1'b0, column_q};
		endcase
		prod       = mul_a * mul_a;
		past_end   = ({xx_q, 1'b0} > {1'b0, rr_q});
		sqrt_start = (state_q == S_CHK) && !past_end;
		y_up       = {1'b0, sqrt_root} + (C+1)'(1);
	end

	cpg_sqrt #(
		.COORD_BITS(C)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.n     (rr_q - xx_q),
		.done  (sqrt_done),
		.root  (sqrt_root),
		.rem   (sqrt_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			radius_q   <= '0;
			column_q   <= '0;
			finished_q <= 1'b1;
			oct_q      <= OCT_XY;
		end else begin
			if (radius_we) begin
				radius_q <= radius_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							column_q   <= '0;
							finished_q <= 1'b0;
							state_q    <= S_RR;
						end else if (!finished_q) begin
							column_q <= column_q + C'(1);
							state_q  <= S_RR;
						end
					end
				end
				S_RR:  state_q <= S_XX;
				S_XX:  state_q <= S_CHK;
				S_CHK: begin
					if (past_end) begin
						finished_q <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_NX;
					end
				end
				S_NX:  state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (done_q) begin
						finished_q <= 1'b1;
					end
					oct_q   <= OCT_XY;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						oct_q <= oct_q + 3'd1;
						if (oct_q == OCT_XNY) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RR) begin
			rr_q <= prod[2*C-1:0];
		end
		if (state_q == S_XX) begin
			xx_q <= prod[2*C-1:0];
		end
		if (state_q == S_NX) begin
			done_q <= ({prod, 1'b0} > {3'b000, rr_q});
		end
		// round to nearest: remainder above y means n > y*y + y
		if (state_q == S_ROUND) begin
			if (sqrt_rem > {2'b00, sqrt_root}) begin
				y_q <= y_up[C-1:0];
			end else begin
				y_q <= sqrt_root;
			end
		end
	end

	logic signed [C:0] xs, ys, nxs, nys;

	always_comb begin
		xs  = signed'({1'b0, column_q});
		ys  = signed'({1'b0, y_q});
		nxs = -xs;
		nys = -ys;
		unique case (oct_q)
			OCT_XY:   begin point_x = xs;  point_y = ys;  end
			OCT_YX:   begin point_x = ys;  point_y = xs;  end
			OCT_NYX:  begin point_x = nys; point_y = xs;  end
			OCT_NXY:  begin point_x = nxs; point_y = ys;  end
			OCT_NXNY: begin point_x = nxs; point_y = nys; end
			OCT_NYNX: begin point_x = nys; point_y = nxs; end
			OCT_YNX:  begin point_x = ys;  point_y = nxs; end
			OCT_XNY:  begin point_x = xs;  point_y = nys; end
			default:  begin point_x = xs;  point_y = ys;  end
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_EMIT);
	assign octant      = oct_q;
	assign last_of_run = (oct_q == OCT_XNY);
	assign arc_done    = done_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while points are pending");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_run) |=> in_ready)
		else $error("block not idle after the eighth point");

	a_final_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && arc_done) |-> finished_q)
		else $error("final column emitted without ending the arc");

	a_first_octant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (octant == OCT_XY))
		else $error("column emission did not start at the first reflection");

endmodule

`default_nettype wire
